### rtl/hssc_pkg.sv
// Package for the hall six-step commutator: command codes, channel codes and commutation tables.
`timescale 1ns / 1ps

package hssc_pkg;

	localparam int CHANGES_PER_MEASURE_DEF = 12;
	localparam int COUNT_WIDTH_DEF         = 32;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_STOP  = 2'd2;

	localparam logic [1:0] CH_U = 2'd0;
	localparam logic [1:0] CH_V = 2'd1;
	localparam logic [1:0] CH_W = 2'd2;

	localparam logic [2:0] HALL_NONE = 3'd0;
	localparam logic [2:0] HALL_ALL  = 3'd7;

	localparam logic [2:0] LOW_U = 3'h4;
	localparam logic [2:0] LOW_V = 3'h2;
	localparam logic [2:0] LOW_W = 3'h1;

	typedef logic [2:0] hall_t;

	// high-side channel for a valid hall code; rev selects reverse direction
	function automatic logic [1:0] high_channel(input logic rev, input hall_t hall);
		logic [1:0] ch;
		ch = CH_U;
		case ({rev, hall})
			4'b0_001: ch = CH_W;
			4'b0_010: ch = CH_V;
			4'b0_011: ch = CH_W;
			4'b0_100: ch = CH_U;
			4'b0_101: ch = CH_U;
			4'b0_110: ch = CH_V;
			4'b1_001: ch = CH_V;
			4'b1_010: ch = CH_U;
			4'b1_011: ch = CH_U;
			4'b1_100: ch = CH_W;
			4'b1_101: ch = CH_V;
			4'b1_110: ch = CH_W;
			default:  ch = CH_U;
		endcase
		return ch;
	endfunction

	// low-side switch mask, U V W as bit2 bit1 bit0
	function automatic logic [2:0] low_mask(input logic rev, input hall_t hall);
		logic [2:0] m;
		m = 3'b000;
		case ({rev, hall})
			4'b0_001: m = LOW_V;
			4'b0_010: m = LOW_U;
			4'b0_011: m = LOW_U;
			4'b0_100: m = LOW_W;
			4'b0_101: m = LOW_V;
			4'b0_110: m = LOW_W;
			4'b1_001: m = LOW_W;
			4'b1_010: m = LOW_V;
			4'b1_011: m = LOW_W;
			4'b1_100: m = LOW_U;
			4'b1_101: m = LOW_U;
			4'b1_110: m = LOW_V;
			default:  m = 3'b000;
		endcase
		return m;
	endfunction

endpackage

### rtl/hall_six_step_commutator_unit.sv
// Hall six-step commutator: command input register, state update and result registers.
`timescale 1ns / 1ps

// Six-step BLDC commutation from three hall bits. Each input beat is a PWM
// tick, a start or a stop, and yields one result beat with the compares, low
// pins, speed period and running flag as they stand after that beat. A beat is
// held in an input register and resolved from there into the state
// registers, which drive the result ports directly; one beat per cycle is
// sustained while the result side takes beats, and result valid is
// registered along with the state when the input register hands a beat on.
module hall_six_step_commutator_unit #(
	parameter int CHANGES_PER_MEASURE = hssc_pkg::CHANGES_PER_MEASURE_DEF,
	parameter int COUNT_WIDTH         = hssc_pkg::COUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             command,
	input  logic [2:0]             hall_code,
	input  logic signed [15:0]     setpoint,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [15:0]            duty_phase_u,
	output logic [15:0]            duty_phase_v,
	output logic [15:0]            duty_phase_w,
	output logic [2:0]             low_pins,
	output logic [COUNT_WIDTH-1:0] speed_period,
	output logic                   motor_running
);

	localparam logic [3:0] CHG_LIMIT = 4'(CHANGES_PER_MEASURE);

	// input stage
	logic              vld_s1;
	logic [1:0]        cmd_s1;
	hssc_pkg::hall_t   hall_s1;
	logic [15:0]       set_s1;

	// state, also the result
	logic                   out_vld_q;
	logic                   running_q;
	hssc_pkg::hall_t        prev_hall_q;
	logic [COUNT_WIDTH-1:0] tick_q;
	logic [3:0]             chg_q;
	logic [COUNT_WIDTH-1:0] period_q;
	logic [15:0]            cmp_u_q, cmp_v_q, cmp_w_q;
	logic [2:0]             low_q;

	logic advance;

	assign advance  = vld_s1 && (!out_vld_q || out_ready);
	assign in_ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1  <= command;
			hall_s1 <= hall_code;
			set_s1  <= setpoint;
		end
	end

	// next-state logic
	logic                   running_d;
	hssc_pkg::hall_t        prev_hall_d;
	logic [COUNT_WIDTH-1:0] tick_d, tick_inc;
	logic [3:0]             chg_d, chg_inc;
	logic [COUNT_WIDTH-1:0] period_d;
	logic [15:0]            cmp_u_d, cmp_v_d, cmp_w_d;
	logic [2:0]             low_d;
	logic                   rev;
	logic [15:0]            duty;
	logic [1:0]             ch;

	always_comb begin
		running_d   = running_q;
		prev_hall_d = prev_hall_q;
		tick_d      = tick_q;
		chg_d       = chg_q;
		period_d    = period_q;
		cmp_u_d     = cmp_u_q;
		cmp_v_d     = cmp_v_q;
		cmp_w_d     = cmp_w_q;
		low_d       = low_q;
		tick_inc    = tick_q + COUNT_WIDTH'(1);
		chg_inc     = chg_q + 4'd1;
		rev         = set_s1[15];
		duty        = rev ? (16'd0 - set_s1) : set_s1;
		ch          = hssc_pkg::high_channel(rev, hall_s1);

		case (cmd_s1)
			hssc_pkg::CMD_TICK: begin
				if (running_q) begin
					tick_d = tick_inc;
					if (hall_s1 != prev_hall_q) begin
						chg_d       = chg_inc;
						prev_hall_d = hall_s1;
						if (chg_inc == CHG_LIMIT) begin
							period_d = tick_inc;
							tick_d   = '0;
							chg_d    = 4'd0;
						end
						if (hall_s1 != hssc_pkg::HALL_NONE && hall_s1 != hssc_pkg::HALL_ALL) begin
							cmp_u_d = (ch == hssc_pkg::CH_U) ? duty : 16'd0;
							cmp_v_d = (ch == hssc_pkg::CH_V) ? duty : 16'd0;
							cmp_w_d = (ch == hssc_pkg::CH_W) ? duty : 16'd0;
							low_d   = hssc_pkg::low_mask(rev, hall_s1);
						end
					end
				end
			end
			hssc_pkg::CMD_START: begin
				running_d = 1'b1;
				cmp_u_d   = 16'd0;
				cmp_v_d   = 16'd0;
				cmp_w_d   = 16'd0;
			end
			hssc_pkg::CMD_STOP: begin
				running_d = 1'b0;
				cmp_u_d   = 16'd0;
				cmp_v_d   = 16'd0;
				cmp_w_d   = 16'd0;
				tick_d    = '0;
				chg_d     = 4'd0;
				period_d  = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q   <= 1'b0;
			running_q   <= 1'b0;
			prev_hall_q <= hssc_pkg::HALL_NONE;
			tick_q      <= '0;
			chg_q       <= 4'd0;
			period_q    <= '0;
			cmp_u_q     <= 16'd0;
			cmp_v_q     <= 16'd0;
			cmp_w_q     <= 16'd0;
			low_q       <= 3'd0;
		end else begin
			if (advance) begin
				out_vld_q   <= 1'b1;
				running_q   <= running_d;
				prev_hall_q <= prev_hall_d;
				tick_q      <= tick_d;
				chg_q       <= chg_d;
				period_q    <= period_d;
				cmp_u_q     <= cmp_u_d;
				cmp_v_q     <= cmp_v_d;
				cmp_w_q     <= cmp_w_d;
				low_q       <= low_d;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_vld_q;
	assign duty_phase_u  = cmp_u_q;
	assign duty_phase_v  = cmp_v_q;
	assign duty_phase_w  = cmp_w_q;
	assign low_pins      = low_q;
	assign speed_period  = period_q;
	assign motor_running = running_q;

endmodule

### sim/tb_top.sv
// Self-checking testbench for the hall six-step commutator unit.
`timescale 1ns / 1ps

module tb_top;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 2000;
	localparam int LIVE_BEATS = 400;
	localparam int HOLD_CYCLES = 60;

	typedef struct packed {
		logic [15:0] u;
		logic [15:0] v;
		logic [15:0] w;
		logic [2:0]  low;
		logic [31:0] period;
		logic        running;
	} drive_t;

	class drive_tracker;
		bit running;
		hssc_pkg::hall_t last_hall;
		bit [31:0] ticks;
		bit [3:0] changes;
		bit [31:0] period;
		bit [15:0] cmp [3];
		bit [2:0] low_side;
		int mismatches;
		drive_t expected_q [$];
		bit [1:0] high_of [2][8] = '{
			'{hssc_pkg::CH_U, hssc_pkg::CH_W, hssc_pkg::CH_V, hssc_pkg::CH_W,
				hssc_pkg::CH_U, hssc_pkg::CH_U, hssc_pkg::CH_V, hssc_pkg::CH_U},
			'{hssc_pkg::CH_U, hssc_pkg::CH_V, hssc_pkg::CH_U, hssc_pkg::CH_U,
				hssc_pkg::CH_W, hssc_pkg::CH_V, hssc_pkg::CH_W, hssc_pkg::CH_U}
		};
		bit [2:0] low_of [2][8] = '{
			'{3'b000, hssc_pkg::LOW_V, hssc_pkg::LOW_U, hssc_pkg::LOW_U,
				hssc_pkg::LOW_W, hssc_pkg::LOW_V, hssc_pkg::LOW_W, 3'b000},
			'{3'b000, hssc_pkg::LOW_W, hssc_pkg::LOW_V, hssc_pkg::LOW_W,
				hssc_pkg::LOW_U, hssc_pkg::LOW_U, hssc_pkg::LOW_V, 3'b000}
		};

		function void record_command(logic [1:0] cmd, hssc_pkg::hall_t hall, logic [15:0] sp);
			drive_t e;
			bit rev;
			bit [15:0] duty;
			case (cmd)
				hssc_pkg::CMD_TICK: begin
					if (running) begin
						ticks++;
						if (hall != last_hall) begin
							changes++;
							if (changes == 4'(hssc_pkg::CHANGES_PER_MEASURE_DEF)) begin
								period = ticks;
								ticks = 0;
								changes = 0;
							end
							last_hall = hall;
							if (hall != hssc_pkg::HALL_NONE && hall != hssc_pkg::HALL_ALL) begin
								rev = sp[15];
								duty = rev ? 16'd0 - sp : sp;
								cmp = '{default: 16'd0};
								cmp[high_of[rev][hall]] = duty;
								low_side = low_of[rev][hall];
							end
						end
					end
				end
				hssc_pkg::CMD_START: begin
					cmp = '{default: 16'd0};
					running = 1'b1;
				end
				hssc_pkg::CMD_STOP: begin
					running = 1'b0;
					cmp = '{default: 16'd0};
					ticks = 0;
					changes = 0;
					period = 0;
				end
				default: ;
			endcase
			e.u = cmp[0];
			e.v = cmp[1];
			e.w = cmp[2];
			e.low = low_side;
			e.period = period;
			e.running = running;
			expected_q.push_back(e);
		endfunction

		function void compare_field(string name, longint unsigned want, longint unsigned got);
			if (want != got) begin
				$error("%s expected %0d got %0d", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_outputs(logic [15:0] u, logic [15:0] v, logic [15:0] w,
				logic [2:0] low, logic [31:0] per, logic run);
			drive_t e;
			if (expected_q.size() == 0) begin
				$error("result beat with nothing expected");
				mismatches++;
				return;
			end
			e = expected_q.pop_front();
			compare_field("duty_phase_u", e.u, u);
			compare_field("duty_phase_v", e.v, v);
			compare_field("duty_phase_w", e.w, w);
			compare_field("low_pins", e.low, low);
			compare_field("speed_period", e.period, per);
			compare_field("motor_running", e.running, run);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [1:0] command;
	logic [2:0] hall_code;
	logic signed [15:0] setpoint;
	logic out_valid;
	logic out_ready;
	logic [15:0] duty_phase_u;
	logic [15:0] duty_phase_v;
	logic [15:0] duty_phase_w;
	logic [2:0] low_pins;
	logic [31:0] speed_period;
	logic motor_running;

	drive_tracker tracker;
	int src_idle_pct;
	int sink_idle_pct;
	int live_beats;
	int quiet_cycles;
	bit hold_request;
	bit hold_done;

	hall_six_step_commutator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.hall_code(hall_code),
		.setpoint(setpoint),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.duty_phase_u(duty_phase_u),
		.duty_phase_v(duty_phase_v),
		.duty_phase_w(duty_phase_w),
		.low_pins(low_pins),
		.speed_period(speed_period),
		.motor_running(motor_running)
	);

	always #6 clk = ~clk;

	task automatic send_beat(input logic [1:0] cmd, input hssc_pkg::hall_t hall,
			input logic signed [15:0] sp);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		hall_code <= hall;
		setpoint <= sp;
		do @(posedge clk); while (!in_ready);
		tracker.record_command(cmd, hall, sp);
		@(negedge clk);
	endtask

	// rotate through the gray hall sequence with dwell, glitches and setpoint changes
	task automatic spin_run(input int steps);
		hssc_pkg::hall_t code_seq [6];
		int pos;
		int dir_step;
		int dwell;
		int r;
		hssc_pkg::hall_t code;
		logic signed [15:0] drive;
		code_seq = '{3'd1, 3'd3, 3'd2, 3'd6, 3'd4, 3'd5};
		pos = $urandom_range(5);
		dir_step = $urandom_range(1) ? 1 : 5;
		dwell = 0;
		drive = 16'($urandom);
		for (int i = 0; i < steps; i++) begin
			r = $urandom_range(99);
			if (r < 8) begin
				code = $urandom_range(1) ? hssc_pkg::HALL_NONE : hssc_pkg::HALL_ALL;
			end else if (r < 12) begin
				code = hssc_pkg::hall_t'($urandom_range(7));
			end else begin
				if (dwell == 0) begin
					pos = (pos + dir_step) % 6;
					dwell = $urandom_range(3);
				end else begin
					dwell--;
				end
				code = code_seq[pos];
			end
			if ($urandom_range(9) == 0)
				drive = 16'($urandom);
			if ($urandom_range(29) == 0)
				drive = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
			send_beat(hssc_pkg::CMD_TICK, code, drive);
			live_beats++;
		end
	endtask

	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			int hold_left;
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_outputs(duty_phase_u, duty_phase_v, duty_phase_w,
				low_pins, speed_period, motor_running);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("hall_six_step_commutator_unit verification failed");
				$finish;
			end
		end
	end

	initial begin
		int r;
		in_valid = 1'b0;
		command = hssc_pkg::CMD_TICK;
		hall_code = 3'd0;
		setpoint = 16'sd0;
		src_idle_pct = 37;
		sink_idle_pct = 53;
		live_beats = 0;
		quiet_cycles = 0;
		hold_request = 1'b0;
		hold_done = 1'b0;
		tracker = new();
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: stopped tick, unused command, every valid code in at least one direction, a full measure
		send_beat(hssc_pkg::CMD_TICK, 3'd5, 16'sd1234);
		send_beat(CMD_UNUSED, 3'd7, 16'sh7FFF);
		send_beat(hssc_pkg::CMD_START, 3'd2, -16'sd5);
		send_beat(hssc_pkg::CMD_TICK, 3'd0, 16'sd100);
		send_beat(hssc_pkg::CMD_TICK, 3'd1, 16'sh7FFF);
		send_beat(hssc_pkg::CMD_TICK, 3'd3, 16'sh8000);
		send_beat(hssc_pkg::CMD_TICK, 3'd2, 16'sd0);
		send_beat(hssc_pkg::CMD_TICK, 3'd6, -16'sd1);
		send_beat(hssc_pkg::CMD_TICK, 3'd4, 16'sh5555);
		send_beat(hssc_pkg::CMD_TICK, 3'd5, 16'shAAAA);
		send_beat(hssc_pkg::CMD_TICK, 3'd7, 16'sd77);
		send_beat(hssc_pkg::CMD_TICK, 3'd7, 16'sd78);
		send_beat(hssc_pkg::CMD_TICK, 3'd0, 16'sd79);
		send_beat(hssc_pkg::CMD_TICK, 3'd1, -16'sd2);
		send_beat(hssc_pkg::CMD_START, 3'd0, 16'sd0);
		send_beat(hssc_pkg::CMD_TICK, 3'd3, 16'sd200);
		send_beat(hssc_pkg::CMD_TICK, 3'd2, -16'sd300);
		send_beat(hssc_pkg::CMD_TICK, 3'd6, 16'sd400);
		send_beat(hssc_pkg::CMD_STOP, 3'd1, 16'sh7FFF);
		send_beat(hssc_pkg::CMD_TICK, 3'd4, 16'sd500);
		send_beat(hssc_pkg::CMD_START, 3'd5, 16'sh8000);
		send_beat(hssc_pkg::CMD_TICK, 3'd6, 16'sd600);
		send_beat(hssc_pkg::CMD_TICK, 3'd2, -16'sd700);

		while (live_beats < LIVE_BEATS) begin
			if (live_beats < LIVE_BEATS / 3) begin
				src_idle_pct = 37;
				sink_idle_pct = 53;
			end else if (live_beats < 2 * LIVE_BEATS / 3) begin
				src_idle_pct = 53;
				sink_idle_pct = 37;
			end else begin
				src_idle_pct = 0;
				sink_idle_pct = 0;
				if (!hold_done) begin
					hold_request = 1'b1;
					hold_done = 1'b1;
				end
			end
			send_beat(hssc_pkg::CMD_START, hssc_pkg::hall_t'($urandom), 16'($urandom));
			live_beats++;
			spin_run($urandom_range(8, 40));
			r = $urandom_range(9);
			if (r < 6) begin
				send_beat(hssc_pkg::CMD_STOP, hssc_pkg::hall_t'($urandom), 16'($urandom));
				live_beats++;
				if ($urandom_range(1))
					send_beat(hssc_pkg::CMD_TICK, hssc_pkg::hall_t'($urandom),
						16'($urandom));
			end
			if ($urandom_range(9) == 0)
				send_beat(CMD_UNUSED, hssc_pkg::hall_t'($urandom), 16'($urandom));
		end
		in_valid <= 1'b0;

		while (tracker.expected_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.expected_q.size() == 0) begin
			$display("hall_six_step_commutator_unit verification clean");
		end else begin
			$display("hall_six_step_commutator_unit verification failed");
		end
		$finish;
	end

endmodule

### hall_six_step_commutator_unit.f
rtl/hssc_pkg.sv
rtl/hall_six_step_commutator_unit.sv
sim/tb_top.sv
